>>> rtl/core/byte_ring_fifo_line_extract_top_defines.svh
// Assertion macros for the byte ring FIFO checker.
`ifndef BYTE_RING_FIFO_LINE_EXTRACT_TOP_DEFINES_SVH
`define BYTE_RING_FIFO_LINE_EXTRACT_TOP_DEFINES_SVH

// Concurrent assertion on a given clock and active-low reset.
`define BRFLE_ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define BRFLE_ASSERT(label, prop, msg) \
    `BRFLE_ASSERT_CLKRST(label, i_clk, i_rst_n, prop, msg)

`endif

>>> rtl/core/brfle_pkg.sv
// Types, codes and constants of the byte ring FIFO with line extraction.
`default_nettype none

package brfle_pkg;

    localparam int CAPACITY    = 63;
    localparam int SLOTS       = CAPACITY + 1;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = 6;
    localparam int LEN_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_LINE  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;
    localparam logic [1:0] ST_NO_LINE  = 2'd3;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd0;
    localparam logic [OP_W-1:0] OP_READ    = 3'd1;
    localparam logic [OP_W-1:0] OP_LINE    = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_BAD_LEN = 3'd4;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] burst_length;
        logic             first_of_burst;
        logic [LEN_W-1:0] read_length;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic             has_data;
        logic [7:0]       out_byte;
        logic             last;
        logic [CNT_W-1:0] fill_count;
        logic [CNT_W-1:0] free_count;
    } t_res;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] burst_length;
        logic             first_of_burst;
        logic [LEN_W-1:0] read_length;
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/core/byte_ring_fifo_line_extract_top.sv
// A write, clear or error result is registered as the back end takes its command from the queue.
// Writes, clears and errors are handled in the idle state, so one such beat per cycle is taken
// while the result register is free or being read. A raw read of N bytes drains N result beats.
// A line read scans for CR, LF or NUL and drains the line, or gives a no-line result if none.
// Synchronous reset empties the ring, the command queue and the result register;
// ring storage is not cleared and needs no clearing pass.
`default_nettype none

module byte_ring_fifo_line_extract_top (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire brfle_pkg::t_req i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output brfle_pkg::t_res      o_out_data
);
    import brfle_pkg::*;

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    brfle_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    brfle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/brfle_front.sv
// Front end: decodes each request beat into a command and queues it for the back end.
`default_nettype none

module brfle_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire brfle_pkg::t_req i_in_data,
    output logic                 o_cmd_valid,
    input  wire logic            i_cmd_ready,
    output brfle_pkg::t_cmd      o_cmd
);
    import brfle_pkg::*;

    t_cmd              w_cmd;
    t_cmd              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_count;
    logic              w_push;
    logic              w_pop;

    always_comb begin
        w_cmd.data_byte      = i_in_data.data_byte;
        w_cmd.burst_length   = i_in_data.burst_length;
        w_cmd.first_of_burst = i_in_data.first_of_burst;
        w_cmd.read_length    = i_in_data.read_length;
        case (i_in_data.req_type)
            REQ_WRITE: begin
                w_cmd.op = OP_WRITE;
            end
            REQ_READ: begin
                w_cmd.op = (i_in_data.read_length == '0) ? OP_BAD_LEN : OP_READ;
            end
            REQ_LINE: begin
                w_cmd.op = OP_LINE;
            end
            default: begin
                w_cmd.op = OP_CLEAR;
            end
        endcase
    end

    assign o_in_ready  = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_buf[r_rp];
    assign w_push      = i_in_valid && o_in_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/brfle_back.sv
// Back end: ring storage, burst admission, raw and line reads, and the result register.
`default_nettype none

module brfle_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    output logic                 o_cmd_ready,
    input  wire brfle_pkg::t_cmd i_cmd,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output brfle_pkg::t_res      o_out_data
);
    import brfle_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    function automatic logic [IDX_W-1:0] f_advance(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] f_fill(input logic [IDX_W-1:0] wr,
                                                input logic [IDX_W-1:0] rd);
        logic [IDX_W:0] diff;
        if (wr >= rd) begin
            diff = {1'b0, wr} - {1'b0, rd};
        end else begin
            diff = (IDX_W+1)'(SLOTS) - {1'b0, rd} + {1'b0, wr};
        end
        return CNT_W'(diff);
    endfunction

    logic [7:0]       r_mem [SLOTS];
    logic [7:0]       r_q;
    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_wr, n_wr;
    logic [IDX_W-1:0] r_rd, n_rd;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic             r_ba, n_ba;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_zero_last, n_zero_last;
    logic [CNT_W-1:0] r_fill_after, n_fill_after;
    logic             r_out_valid;
    t_res             r_out;
    t_res             w_res;
    logic             w_emit;
    logic             w_pop;
    logic             w_mem_we;
    logic             w_load_ok;
    logic [CNT_W-1:0] w_fill;
    logic [CNT_W-1:0] w_free;

    assign w_fill      = f_fill(r_wr, r_rd);
    assign w_free      = CNT_W'(CAPACITY) - w_fill;
    assign w_load_ok   = !r_out_valid || i_out_ready;
    assign o_cmd_ready = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        logic [1:0]       v_status;
        logic [CNT_W-1:0] v_cnt;
        logic [CNT_W-1:0] v_after;
        n_state      = r_state;
        n_wr         = r_wr;
        n_rd         = r_rd;
        n_ptr        = r_ptr;
        n_ba         = r_ba;
        n_cnt        = r_cnt;
        n_zero_last  = r_zero_last;
        n_fill_after = r_fill_after;
        w_pop        = 1'b0;
        w_emit       = 1'b0;
        w_mem_we     = 1'b0;
        w_res        = '0;
        v_status     = ST_OK;
        v_cnt        = '0;
        v_after      = w_fill;
        case (r_state)
            S_IDLE: begin
                n_ptr = r_rd;
                if (i_cmd_valid && w_load_ok) begin
                    w_pop = 1'b1;
                    case (i_cmd.op)
                        OP_WRITE: begin
                            if (i_cmd.first_of_burst) begin
                                if (i_cmd.burst_length == '0) begin
                                    v_status = ST_BAD_LEN;
                                    n_ba     = 1'b0;
                                end else if (i_cmd.burst_length > w_free) begin
                                    v_status = ST_NO_SPACE;
                                    n_ba     = 1'b0;
                                end else begin
                                    n_ba = 1'b1;
                                end
                            end else if (!r_ba) begin
                                v_status = ST_NO_SPACE;
                            end
                            if (v_status == ST_OK) begin
                                if (w_fill >= CNT_W'(CAPACITY)) begin
                                    v_status = ST_NO_SPACE;
                                end else begin
                                    w_mem_we = 1'b1;
                                    n_wr     = f_advance(r_wr);
                                    v_after  = w_fill + 1'b1;
                                end
                            end
                            w_emit = 1'b1;
                        end
                        OP_BAD_LEN: begin
                            v_status = ST_BAD_LEN;
                            w_emit   = 1'b1;
                        end
                        OP_READ: begin
                            v_cnt = (i_cmd.read_length < w_fill) ? i_cmd.read_length : w_fill;
                            if (v_cnt == '0) begin
                                w_emit = 1'b1;
                            end else begin
                                n_cnt        = v_cnt;
                                n_zero_last  = 1'b0;
                                n_fill_after = w_fill - v_cnt;
                                n_state      = S_DRAIN;
                            end
                        end
                        OP_LINE: begin
                            n_cnt   = '0;
                            n_state = S_SCAN;
                        end
                        OP_CLEAR: begin
                            n_wr    = '0;
                            n_rd    = '0;
                            n_ptr   = '0;
                            n_ba    = 1'b0;
                            v_after = '0;
                            w_emit  = 1'b1;
                        end
                        default: begin
                            w_emit = 1'b1;
                        end
                    endcase
                    w_res.status     = v_status;
                    w_res.last       = 1'b1;
                    w_res.fill_count = v_after;
                    w_res.free_count = CNT_W'(CAPACITY) - v_after;
                end
            end
            S_SCAN: begin
                if (r_cnt == w_fill) begin
                    n_ptr = r_rd;
                    if (w_load_ok) begin
                        w_emit           = 1'b1;
                        w_res.status     = ST_NO_LINE;
                        w_res.last       = 1'b1;
                        w_res.fill_count = w_fill;
                        w_res.free_count = w_free;
                        n_state          = S_IDLE;
                    end
                end else if (r_q == CH_CR || r_q == CH_LF || r_q == CH_NUL) begin
                    n_cnt        = r_cnt + 1'b1;
                    n_zero_last  = 1'b1;
                    n_fill_after = w_fill - (r_cnt + 1'b1);
                    n_ptr        = r_rd;
                    n_state      = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                    n_ptr = f_advance(r_ptr);
                end
            end
            S_DRAIN: begin
                if (w_load_ok) begin
                    w_emit           = 1'b1;
                    w_res.status     = ST_OK;
                    w_res.has_data   = 1'b1;
                    w_res.last       = (r_cnt == CNT_W'(1));
                    w_res.out_byte   = (w_res.last && r_zero_last) ? CH_NUL : r_q;
                    w_res.fill_count = r_fill_after;
                    w_res.free_count = CNT_W'(CAPACITY) - r_fill_after;
                    n_rd             = f_advance(r_rd);
                    n_ptr            = f_advance(r_ptr);
                    n_cnt            = r_cnt - 1'b1;
                    if (w_res.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_wr] <= i_cmd.data_byte;
        end
        r_q <= r_mem[n_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_res;
        end
        r_cnt        <= n_cnt;
        r_zero_last  <= n_zero_last;
        r_fill_after <= n_fill_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr        <= '0;
            r_rd        <= '0;
            r_ptr       <= '0;
            r_ba        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_ptr   <= n_ptr;
            r_ba    <= n_ba;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/brfle_checker.sv
// Port-level checker for the byte ring FIFO top level and its bind.
`include "byte_ring_fifo_line_extract_top_defines.svh"
`default_nettype none

module brfle_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire brfle_pkg::t_res o_out_data
);
    import brfle_pkg::*;

    `BRFLE_ASSERT(a_counts_sum, o_out_valid |-> (((CNT_W+1)'(o_out_data.fill_count) + (CNT_W+1)'(o_out_data.free_count)) == (CNT_W+1)'(CAPACITY)), "fill and free counts do not add up to capacity")
    `BRFLE_ASSERT(a_nodata_single, (o_out_valid && !o_out_data.has_data) |-> ((o_out_data.out_byte == 8'h00) && o_out_data.last), "beat without data is not a single zero result")
    `BRFLE_ASSERT(a_error_nodata, (o_out_valid && (o_out_data.status != ST_OK)) |-> !o_out_data.has_data, "error beat carries data")
    `BRFLE_ASSERT(a_stall_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)), "stalled result beat changed")

endmodule

bind byte_ring_fifo_line_extract_top brfle_checker u_checker (.*);

`default_nettype wire

>>> tb/byte_ring_fifo_line_extract_top_tb.sv
// Self-checking testbench for the byte ring FIFO with burst writes, raw reads and line reads.
`default_nettype none

module byte_ring_fifo_line_extract_top_tb;
    import brfle_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_res o_out_data;

    byte_ring_fifo_line_extract_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    logic [7:0]       ring_mem [SLOTS];
    logic [IDX_W-1:0] ring_wr;
    logic [IDX_W-1:0] ring_rd;
    logic             burst_open;

    t_res        pending_results[$];
    int unsigned beats_sent;
    int unsigned beats_seen;
    int unsigned mismatches;
    bit          quiet_mode;

    initial begin
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic int ring_fill();
        if (ring_wr >= ring_rd) begin
            return int'(ring_wr) - int'(ring_rd);
        end
        return SLOTS - int'(ring_rd) + int'(ring_wr);
    endfunction

    // Computes the result beats caused by one accepted request and queues them.
    function automatic void ring_predict(input t_req req);
        t_res             step_out[$];
        t_res             res;
        int               fill;
        int               take;
        int               line_len;
        bit               zero_term;
        logic [1:0]       st;
        logic [IDX_W-1:0] pos;
        logic [7:0]       c;

        fill = ring_fill();
        take = 0;
        zero_term = 1'b0;
        res = '0;
        res.last = 1'b1;
        case (req.req_type)
            REQ_WRITE: begin
                st = ST_OK;
                if (req.first_of_burst) begin
                    if (req.burst_length == '0) begin
                        st = ST_BAD_LEN;
                        burst_open = 1'b0;
                    end else if (int'(req.burst_length) > CAPACITY - fill) begin
                        st = ST_NO_SPACE;
                        burst_open = 1'b0;
                    end else begin
                        burst_open = 1'b1;
                    end
                end else if (!burst_open) begin
                    st = ST_NO_SPACE;
                end
                if (st == ST_OK) begin
                    if (fill >= CAPACITY) begin
                        st = ST_NO_SPACE;
                    end else begin
                        ring_mem[ring_wr] = req.data_byte;
                        ring_wr = ring_next(ring_wr);
                    end
                end
                res.status = st;
                step_out.push_back(res);
            end
            REQ_READ: begin
                if (req.read_length == '0) begin
                    res.status = ST_BAD_LEN;
                    step_out.push_back(res);
                end else begin
                    take = (int'(req.read_length) < fill) ? int'(req.read_length) : fill;
                    if (take == 0) begin
                        step_out.push_back(res);
                    end
                end
            end
            REQ_LINE: begin
                pos = ring_rd;
                line_len = 0;
                for (int i = 0; i < fill && line_len == 0; i++) begin
                    c = ring_mem[pos];
                    if (c == CH_CR || c == CH_LF || c == CH_NUL) begin
                        line_len = i + 1;
                    end
                    pos = ring_next(pos);
                end
                if (line_len == 0) begin
                    res.status = ST_NO_LINE;
                    step_out.push_back(res);
                end else begin
                    take = line_len;
                    zero_term = 1'b1;
                end
            end
            default: begin
                ring_wr = '0;
                ring_rd = '0;
                burst_open = 1'b0;
                step_out.push_back(res);
            end
        endcase

        for (int i = 0; i < take; i++) begin
            res = '0;
            res.status = ST_OK;
            res.has_data = 1'b1;
            res.last = (i == take - 1);
            res.out_byte = (res.last && zero_term) ? 8'h00 : ring_mem[ring_rd];
            ring_rd = ring_next(ring_rd);
            step_out.push_back(res);
        end

        fill = ring_fill();
        foreach (step_out[k]) begin
            step_out[k].fill_count = CNT_W'(fill);
            step_out[k].free_count = CNT_W'(CAPACITY - fill);
            pending_results.push_back(step_out[k]);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (quiet_mode) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_req make_req(input logic [1:0] kind, input logic [7:0] data,
                                      input logic [LEN_W-1:0] blen, input logic first,
                                      input logic [LEN_W-1:0] rlen);
        t_req req;
        req.req_type = kind;
        req.data_byte = data;
        req.burst_length = blen;
        req.first_of_burst = first;
        req.read_length = rlen;
        return req;
    endfunction

    function automatic logic [7:0] rand_byte(input int unsigned term_pct);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < term_pct) begin
            case ($urandom_range(0, 2))
                0: b = CH_CR;
                1: b = CH_LF;
                default: b = CH_NUL;
            endcase
        end else if (b == CH_CR || b == CH_LF || b == CH_NUL) begin
            b = 8'h20;
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] result beat %0d: %s got %0h, want %0h",
                     $time, beats_seen, what, got, want);
        end
    endtask

    task automatic send_req(input t_req req);
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_in_data <= req;
        do @(posedge i_clk); while (!o_in_ready);
        ring_predict(req);
        beats_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_burst(input logic [LEN_W-1:0] blen, input int unsigned nbytes,
                              input int unsigned term_pct);
        for (int i = 0; i < nbytes; i++) begin
            send_req(make_req(REQ_WRITE, rand_byte(term_pct), blen, i == 0,
                              LEN_W'($urandom())));
        end
    endtask

    initial begin : out_pacer
        int unsigned hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold != 0) begin
                hold--;
            end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                hold = pick_gap();
            end else begin
                i_out_ready <= 1'b1;
                hold = $urandom_range(0, 8);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("beat with none expected", o_out_data, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
                if (o_out_data.has_data !== want.has_data)
                    report_mismatch("has_data", o_out_data.has_data, want.has_data);
                if (o_out_data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", o_out_data.out_byte, want.out_byte);
                if (o_out_data.last !== want.last)
                    report_mismatch("last", o_out_data.last, want.last);
                if (o_out_data.fill_count !== want.fill_count)
                    report_mismatch("fill_count", o_out_data.fill_count, want.fill_count);
                if (o_out_data.free_count !== want.free_count)
                    report_mismatch("free_count", o_out_data.free_count, want.free_count);
            end
        end
    end

    task automatic test_directed();
        logic [7:0] line_bytes [7];
        line_bytes = '{8'h41, 8'hFF, CH_CR, CH_LF, 8'h42, CH_NUL, 8'h7F};
        send_req(make_req(REQ_CLEAR, 8'h00, 6'd0, 1'b0, 6'd0));
        send_req(make_req(REQ_READ, 8'hFF, 6'd63, 1'b1, 6'd0));
        send_req(make_req(REQ_READ, 8'h00, 6'd0, 1'b0, 6'd63));
        send_req(make_req(REQ_LINE, 8'h00, 6'd0, 1'b0, 6'd0));
        send_req(make_req(REQ_WRITE, 8'hFF, 6'd0, 1'b1, 6'd0));
        send_req(make_req(REQ_WRITE, 8'h12, 6'd5, 1'b0, 6'd0));
        foreach (line_bytes[i]) begin
            send_req(make_req(REQ_WRITE, line_bytes[i], 6'd7, i == 0, 6'd63));
        end
        send_req(make_req(REQ_WRITE, 8'h00, 6'd63, 1'b1, 6'd0));
        send_req(make_req(REQ_WRITE, 8'h33, 6'd63, 1'b0, 6'd0));
        repeat (4) begin
            send_req(make_req(REQ_LINE, 8'hFF, 6'd63, 1'b1, 6'd63));
        end
        send_req(make_req(REQ_READ, 8'h00, 6'd0, 1'b0, 6'd63));
        send_req(make_req(REQ_WRITE, 8'h00, 6'd1, 1'b1, 6'd0));
        send_req(make_req(REQ_READ, 8'h00, 6'd0, 1'b0, 6'd1));
        send_req(make_req(REQ_WRITE, 8'h55, 6'd2, 1'b1, 6'd0));
        send_req(make_req(REQ_CLEAR, 8'hFF, 6'd63, 1'b1, 6'd63));
        send_req(make_req(REQ_READ, 8'h00, 6'd0, 1'b0, 6'd1));
    endtask

    task automatic test_random_traffic(input int unsigned target);
        int unsigned pick;
        int unsigned roll;
        int unsigned free;
        int unsigned blen;
        int unsigned nbytes;
        logic [LEN_W-1:0] rlen;
        while (beats_sent < target) begin
            quiet_mode = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            free = CAPACITY - ring_fill();
            if (pick < 40) begin
                if (free != 0 && $urandom_range(0, 9) != 0) begin
                    blen = $urandom_range(1, (free < 10) ? free : 10);
                end else begin
                    blen = $urandom_range((free < CAPACITY) ? free + 1 : 1, CAPACITY);
                end
                roll = $urandom_range(0, 9);
                if (roll == 0 && blen > 1) begin
                    nbytes = blen - 1;
                end else if (roll == 1) begin
                    nbytes = blen + $urandom_range(1, 3);
                end else begin
                    nbytes = blen;
                end
                send_burst(LEN_W'(blen), nbytes, 15);
            end else if (pick < 65) begin
                send_req(make_req(REQ_LINE, 8'($urandom()), LEN_W'($urandom()), 1'($urandom()),
                                  LEN_W'($urandom())));
            end else if (pick < 85) begin
                roll = $urandom_range(0, 9);
                rlen = (roll == 0) ? 6'd0 : (roll == 1) ? 6'd63 : LEN_W'($urandom_range(1, 8));
                send_req(make_req(REQ_READ, 8'($urandom()), LEN_W'($urandom()), 1'($urandom()),
                                  rlen));
            end else if (pick < 90) begin
                send_req(make_req(REQ_CLEAR, 8'($urandom()), LEN_W'($urandom()),
                                  1'($urandom()), LEN_W'($urandom())));
            end else begin
                send_req(t_req'($urandom()));
            end
        end
        quiet_mode = 1'b0;
    endtask

    task automatic test_full_ring();
        send_req(make_req(REQ_READ, 8'h00, 6'd0, 1'b0, 6'd63));
        quiet_mode = 1'b1;
        send_burst(6'd63, 32, 0);
        quiet_mode = 1'b0;
        for (int i = 0; i < 31; i++) begin
            send_req(make_req(REQ_WRITE, rand_byte(0), 6'd63, 1'b0, 6'd0));
        end
        send_req(make_req(REQ_WRITE, 8'hA5, 6'd63, 1'b0, 6'd0));
        send_req(make_req(REQ_WRITE, 8'h5A, 6'd1, 1'b1, 6'd0));
        send_req(make_req(REQ_LINE, 8'h00, 6'd0, 1'b0, 6'd0));
        send_req(make_req(REQ_READ, 8'h00, 6'd0, 1'b0, 6'd63));
    endtask

    initial begin : main
        ring_wr = '0;
        ring_rd = '0;
        burst_open = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(beats_sent + 80);
        test_full_ring();

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Covered %0d request beats and %0d result beats: bursts, rejected bursts,",
                 beats_sent, beats_seen);
        $display("raw and line reads, clears, a full ring with overrun, under random stalls.");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/brfle_pkg.sv
rtl/core/brfle_front.sv
rtl/core/brfle_back.sv
rtl/core/byte_ring_fifo_line_extract_top.sv
rtl/core/brfle_checker.sv
tb/byte_ring_fifo_line_extract_top_tb.sv
